[rtl/poi_pkg.sv]
// shared constants, types and the arctangent table for the odometry integrator
`default_nettype none
package poi_pkg;

   // cordic setup
   localparam int CORDIC_STEPS = 16;
   localparam int CNT_W = 5;
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [31:0] UNIT_POS = 32'sd1073741824;
   localparam logic signed [31:0] UNIT_NEG = -32'sd1073741824;

   // radians (2^-28) to binary angle scale, Q30
   localparam logic [31:0] RAD_TO_BAM = 32'd2734261102;

   // request field widths
   localparam int TIME_W = 16;
   localparam int VEL_W = 16;
   localparam int POS_W = 32;
   localparam int ANG_W = 32;
   localparam int QUAT_W = 16;

   // sequencer states
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_ROT   = 8'b0000_0010,
      ST_VMUL  = 8'b0000_0100,
      ST_DMUL  = 8'b0000_1000,
      ST_HWAIT = 8'b0001_0000,
      ST_UPD   = 8'b0010_0000,
      ST_QUAT  = 8'b0100_0000,
      ST_FIN   = 8'b1000_0000
   } state_type;

   // heading path phases
   typedef enum logic [2:0] {
      HP_RATE = 3'b001,
      HP_SCALE = 3'b010,
      HP_DONE = 3'b100
   } hphase_type;

   // arctangent of 2^-i in binary angle units
   function automatic logic [31:0] atan_bam(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0: r = 32'd536870912;
         5'd1: r = 32'd316933406;
         5'd2: r = 32'd167458907;
         5'd3: r = 32'd85004756;
         5'd4: r = 32'd42667331;
         5'd5: r = 32'd21354465;
         5'd6: r = 32'd10679838;
         5'd7: r = 32'd5340245;
         5'd8: r = 32'd2670163;
         5'd9: r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         5'd24: r = 32'd41;
         5'd25: r = 32'd20;
         5'd26: r = 32'd10;
         5'd27: r = 32'd5;
         5'd28: r = 32'd3;
         5'd29: r = 32'd1;
         5'd30: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/planar_odometry_integrator.sv]
// planar dead-reckoning odometry integrator with iterative cordic and serial multipliers
//
// Request channel (req_*): time step and body-frame velocities, accepted when
// req_valid is high and req_stall is low. The block takes one request at a time.
// Response channel (rsp_*): world position, heading binary angle and the
// half-angle quaternion z and w terms, one response per request.
// Each request runs, from acceptance to a valid response: a cordic rotation
// on the old heading (one micro-rotation a cycle), a bit-serial velocity
// rotate and time scale while the heading delta is formed bit-serially in
// parallel, a wait state until the heading delta is done, an update state, a
// second cordic on the half heading for the quaternion and a final state that
// loads the output register.
// The next request can be taken in the cycle after the output register is loaded.
// The response sits in an output register, so a new request is taken while an
// earlier response is still stalled; a finished request waits at the end of its
// sequence until the output register is free.
// Reset (synchronous, active high) clears position and heading to zero and
// empties the output register.
`default_nettype none
module planar_odometry_integrator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [poi_pkg::TIME_W-1:0]          req_step_time,
   input  wire logic signed [poi_pkg::VEL_W-1:0]    req_body_vel_x,
   input  wire logic signed [poi_pkg::VEL_W-1:0]    req_body_vel_y,
   input  wire logic signed [poi_pkg::VEL_W-1:0]    req_yaw_rate,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [poi_pkg::POS_W-1:0]         rsp_world_x,
   output logic signed [poi_pkg::POS_W-1:0]         rsp_world_y,
   output logic [poi_pkg::ANG_W-1:0]                rsp_heading_angle,
   output logic signed [poi_pkg::QUAT_W-1:0]        rsp_quat_z,
   output logic signed [poi_pkg::QUAT_W-1:0]        rsp_quat_w
);
   import poi_pkg::*;

   state_type state_ff, state_in;
   hphase_type hph_ff, hph_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] hcnt_ff, hcnt_in;

   // latched request
   logic [TIME_W-1:0] dt_ff, dt_in;
   logic signed [VEL_W-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic wneg_ff, wneg_in;
   logic [VEL_W-1:0] wabs_ff, wabs_in;

   // pose state
   logic signed [POS_W-1:0] posx_ff, posx_in, posy_ff, posy_in;
   logic [ANG_W:0] head_ff, head_in;

   // cordic unit
   logic signed [32:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic cflip_ff, cflip_in;

   // serial accumulators
   logic signed [48:0] acca_ff, acca_in, accb_ff, accb_in;
   logic signed [64:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [30:0] hmag_ff, hmag_in;
   logic [62:0] hprod_ff, hprod_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [ANG_W-1:0] oh_ff, oh_in;
   logic signed [QUAT_W-1:0] oz_ff, oz_in, ow_ff, ow_in;

   logic req_acc;
   logic signed [31:0] cos_val, sin_val;
   logic signed [32:0] xs, ys;
   logic signed [31:0] xc, yc;
   logic [31:0] ld_ang, ld_adj;
   logic ld_flip;
   logic [3:0] bidx;
   logic signed [48:0] ta, tb, ec, es;
   logic signed [64:0] rx, ry;
   logic signed [33:0] sumx, sumy;
   logic [32:0] dh;
   logic signed [32:0] qwr, qzr;
   logic last_rot;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_world_x = ox_ff;
   assign rsp_world_y = oy_ff;
   assign rsp_heading_angle = oh_ff;
   assign rsp_quat_z = oz_ff;
   assign rsp_quat_w = ow_ff;

   // cordic micro-rotation and result clamp
   always_comb begin
      xs = cx_ff >>> cnt_ff;
      ys = cy_ff >>> cnt_ff;
      if (cx_ff > 33'(UNIT_POS)) begin
         xc = UNIT_POS;
      end else if (cx_ff < 33'(UNIT_NEG)) begin
         xc = UNIT_NEG;
      end else begin
         xc = cx_ff[31:0];
      end
      if (cy_ff > 33'(UNIT_POS)) begin
         yc = UNIT_POS;
      end else if (cy_ff < 33'(UNIT_NEG)) begin
         yc = UNIT_NEG;
      end else begin
         yc = cy_ff[31:0];
      end
      cos_val = cflip_ff ? -xc : xc;
      sin_val = cflip_ff ? -yc : yc;
      last_rot = (cnt_ff == CNT_W'(CORDIC_STEPS - 1));
   end

   // cordic load from a binary angle, quadrant fold
   always_comb begin
      ld_ang = (state_ff == ST_UPD) ? head_in[32:1] : head_ff[31:0];
      ld_flip = (ld_ang[31:30] == 2'b01) || (ld_ang[31:30] == 2'b10);
      ld_adj = ld_flip ? (ld_ang - 32'h8000_0000) : ld_ang;
   end

   // serial multiply terms
   always_comb begin
      bidx = cnt_ff[3:0];
      ec = 49'(cos_val);
      es = 49'(sin_val);
      ta = (vx_ff[bidx] ? ec : 49'sd0) - (vy_ff[bidx] ? es : 49'sd0);
      tb = (vx_ff[bidx] ? es : 49'sd0) + (vy_ff[bidx] ? ec : 49'sd0);
      if (bidx == 4'd15) begin
         ta = -ta;
         tb = -tb;
      end
   end

   // rounding, saturation and heading delta
   always_comb begin
      rx = (dx_ff + 65'sd2199023255552) >>> 42;
      ry = (dy_ff + 65'sd2199023255552) >>> 42;
      sumx = 34'(posx_ff) + rx[33:0];
      sumy = 34'(posy_ff) + ry[33:0];
      dh = 33'((hprod_ff + 63'd536870912) >> 30);
      qwr = (33'(cos_val) + 33'sd32768) >>> 16;
      qzr = (33'(sin_val) + 33'sd32768) >>> 16;
   end

   // sequencer and datapath
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      hph_in = hph_ff;
      hcnt_in = hcnt_ff;
      dt_in = dt_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      wneg_in = wneg_ff;
      wabs_in = wabs_ff;
      posx_in = posx_ff;
      posy_in = posy_ff;
      head_in = head_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      cflip_in = cflip_ff;
      acca_in = acca_ff;
      accb_in = accb_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      hmag_in = hmag_ff;
      hprod_in = hprod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ox_in = ox_ff;
      oy_in = oy_ff;
      oh_in = oh_ff;
      oz_in = oz_ff;
      ow_in = ow_ff;

      // heading update needs the new angle before the quaternion load
      if (state_ff == ST_UPD) begin
         head_in = wneg_ff ? (head_ff - dh) : (head_ff + dh);
      end

      // cordic micro-rotation
      if (state_ff == ST_ROT || state_ff == ST_QUAT) begin
         if (!cz_ff[32]) begin
            cx_in = cx_ff - ys;
            cy_in = cy_ff + xs;
            cz_in = cz_ff - 33'(atan_bam(cnt_ff));
         end else begin
            cx_in = cx_ff + ys;
            cy_in = cy_ff - xs;
            cz_in = cz_ff + 33'(atan_bam(cnt_ff));
         end
      end

      // heading delta, bit-serial, msb first
      case (hph_ff)
         HP_RATE: begin
            hmag_in = {hmag_ff[29:0], 1'b0}
               + (dt_ff[hcnt_ff[3:0]] ? 31'(wabs_ff) : 31'd0);
            if (hcnt_ff == '0) begin
               hph_in = HP_SCALE;
               hcnt_in = CNT_W'(30);
               hprod_in = '0;
            end else begin
               hcnt_in = hcnt_ff - 1'b1;
            end
         end
         HP_SCALE: begin
            hprod_in = {hprod_ff[61:0], 1'b0}
               + (hmag_ff[hcnt_ff] ? 63'(RAD_TO_BAM) : 63'd0);
            if (hcnt_ff == '0) begin
               hph_in = HP_DONE;
            end else begin
               hcnt_in = hcnt_ff - 1'b1;
            end
         end
         default: begin
            hph_in = hph_ff;
         end
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               dt_in = req_step_time;
               vx_in = req_body_vel_x;
               vy_in = req_body_vel_y;
               wneg_in = req_yaw_rate[VEL_W-1];
               wabs_in = req_yaw_rate[VEL_W-1] ? (~req_yaw_rate + 1'b1) : req_yaw_rate;
               hph_in = HP_RATE;
               hcnt_in = CNT_W'(15);
               hmag_in = '0;
               cx_in = CORDIC_GAIN;
               cy_in = '0;
               cz_in = {ld_adj[31], ld_adj};
               cflip_in = ld_flip;
               cnt_in = '0;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            if (last_rot) begin
               cnt_in = CNT_W'(15);
               acca_in = '0;
               accb_in = '0;
               state_in = ST_VMUL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_VMUL: begin
            acca_in = {acca_ff[47:0], 1'b0} + ta;
            accb_in = {accb_ff[47:0], 1'b0} + tb;
            if (cnt_ff == '0) begin
               cnt_in = CNT_W'(15);
               dx_in = '0;
               dy_in = '0;
               state_in = ST_DMUL;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DMUL: begin
            dx_in = {dx_ff[63:0], 1'b0} + (dt_ff[bidx] ? 65'(acca_ff) : 65'sd0);
            dy_in = {dy_ff[63:0], 1'b0} + (dt_ff[bidx] ? 65'(accb_ff) : 65'sd0);
            if (cnt_ff == '0) begin
               state_in = ST_HWAIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_HWAIT: begin
            if (hph_ff == HP_DONE) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (sumx > 34'sd2147483647) begin
               posx_in = 32'sh7FFF_FFFF;
            end else if (sumx < -34'sd2147483648) begin
               posx_in = 32'sh8000_0000;
            end else begin
               posx_in = sumx[31:0];
            end
            if (sumy > 34'sd2147483647) begin
               posy_in = 32'sh7FFF_FFFF;
            end else if (sumy < -34'sd2147483648) begin
               posy_in = 32'sh8000_0000;
            end else begin
               posy_in = sumy[31:0];
            end
            cx_in = CORDIC_GAIN;
            cy_in = '0;
            cz_in = {ld_adj[31], ld_adj};
            cflip_in = ld_flip;
            cnt_in = '0;
            state_in = ST_QUAT;
         end
         ST_QUAT: begin
            if (last_rot) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               ox_in = posx_ff;
               oy_in = posy_ff;
               oh_in = head_ff[31:0];
               ow_in = qwr[15:0];
               oz_in = qzr[15:0];
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hph_ff <= HP_DONE;
         cnt_ff <= '0;
         hcnt_ff <= '0;
         posx_ff <= '0;
         posy_ff <= '0;
         head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hph_ff <= hph_in;
         cnt_ff <= cnt_in;
         hcnt_ff <= hcnt_in;
         posx_ff <= posx_in;
         posy_ff <= posy_in;
         head_ff <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dt_ff <= dt_in;
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      wneg_ff <= wneg_in;
      wabs_ff <= wabs_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      cflip_ff <= cflip_in;
      acca_ff <= acca_in;
      accb_ff <= accb_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      hmag_ff <= hmag_in;
      hprod_ff <= hprod_in;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      oh_ff <= oh_in;
      oz_ff <= oz_in;
      ow_ff <= ow_in;
   end

endmodule
`default_nettype wire
